[sv/tvce_pkg.sv]
// Package for the turtle vector command engine: field widths, command
// codes, the queued operation type and the Q1.16 sine lookup.
// No dependencies.
package tvce_pkg;

	localparam int CMD_W     = 3;
	localparam int AMT_W     = 16;
	localparam int COORD_W   = 16;
	localparam int CENTER_W  = 12;
	localparam int CFG_IDX_W = 1;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 64;

	localparam int HEAD_W    = 10;
	localparam int ANGLE_W   = 11;
	localparam int TRIG_W    = 18;
	localparam int STEP_W    = 17;
	localparam int TRIG_FRAC = 16;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [CMD_W-1:0] CMD_FORWARD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BACK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

	localparam logic [CENTER_W-1:0] CENTER_X_RST = 12'd512;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST = 12'd384;

	// floor(n * RECIP_360 >> RECIP_SH) == n / 360 for n < 74898
	localparam logic [15:0] RECIP_360 = 16'd46604;
	localparam int          RECIP_SH  = 24;

	typedef enum logic [1:0] {
		KIND_MOVE,
		KIND_TURN,
		KIND_PEN_UP,
		KIND_PEN_DOWN
	} kind_t;

	// step: signed distance or signed degrees, already negated for back/left
	typedef struct packed {
		kind_t                    kind;
		logic signed [STEP_W-1:0] step;
	} op_t;

	// round(65536 * sin(i deg)) for i = 0..90
	function automatic logic [16:0] sin_mag(input logic [6:0] i);
		logic [16:0] m;
		case (i)
			7'd0: m = 17'd0;         7'd1: m = 17'd1144;      7'd2: m = 17'd2287;
			7'd3: m = 17'd3430;      7'd4: m = 17'd4572;      7'd5: m = 17'd5712;
			7'd6: m = 17'd6850;      7'd7: m = 17'd7987;      7'd8: m = 17'd9121;
			7'd9: m = 17'd10252;     7'd10: m = 17'd11380;    7'd11: m = 17'd12505;
			7'd12: m = 17'd13626;    7'd13: m = 17'd14742;    7'd14: m = 17'd15854;
			7'd15: m = 17'd16962;    7'd16: m = 17'd18064;    7'd17: m = 17'd19161;
			7'd18: m = 17'd20252;    7'd19: m = 17'd21336;    7'd20: m = 17'd22414;
			7'd21: m = 17'd23486;    7'd22: m = 17'd24550;    7'd23: m = 17'd25607;
			7'd24: m = 17'd26655;    7'd25: m = 17'd27696;    7'd26: m = 17'd28729;
			7'd27: m = 17'd29752;    7'd28: m = 17'd30767;    7'd29: m = 17'd31772;
			7'd30: m = 17'd32768;    7'd31: m = 17'd33754;    7'd32: m = 17'd34729;
			7'd33: m = 17'd35693;    7'd34: m = 17'd36647;    7'd35: m = 17'd37590;
			7'd36: m = 17'd38521;    7'd37: m = 17'd39440;    7'd38: m = 17'd40348;
			7'd39: m = 17'd41243;    7'd40: m = 17'd42125;    7'd41: m = 17'd42995;
			7'd42: m = 17'd43852;    7'd43: m = 17'd44695;    7'd44: m = 17'd45525;
			7'd45: m = 17'd46341;    7'd46: m = 17'd47143;    7'd47: m = 17'd47930;
			7'd48: m = 17'd48703;    7'd49: m = 17'd49461;    7'd50: m = 17'd50204;
			7'd51: m = 17'd50931;    7'd52: m = 17'd51643;    7'd53: m = 17'd52340;
			7'd54: m = 17'd53020;    7'd55: m = 17'd53684;    7'd56: m = 17'd54332;
			7'd57: m = 17'd54963;    7'd58: m = 17'd55578;    7'd59: m = 17'd56175;
			7'd60: m = 17'd56756;    7'd61: m = 17'd57319;    7'd62: m = 17'd57865;
			7'd63: m = 17'd58393;    7'd64: m = 17'd58903;    7'd65: m = 17'd59396;
			7'd66: m = 17'd59870;    7'd67: m = 17'd60326;    7'd68: m = 17'd60764;
			7'd69: m = 17'd61183;    7'd70: m = 17'd61584;    7'd71: m = 17'd61966;
			7'd72: m = 17'd62329;    7'd73: m = 17'd62672;    7'd74: m = 17'd62997;
			7'd75: m = 17'd63303;    7'd76: m = 17'd63589;    7'd77: m = 17'd63856;
			7'd78: m = 17'd64104;    7'd79: m = 17'd64332;    7'd80: m = 17'd64540;
			7'd81: m = 17'd64729;    7'd82: m = 17'd64898;    7'd83: m = 17'd65048;
			7'd84: m = 17'd65177;    7'd85: m = 17'd65287;    7'd86: m = 17'd65376;
			7'd87: m = 17'd65446;    7'd88: m = 17'd65496;    7'd89: m = 17'd65526;
			7'd90: m = 17'd65536;
			default: m = 17'd0;
		endcase
		return m;
	endfunction

	// Q1.16 sine of a whole-degree angle in -449..449, quadrant folded
	function automatic logic signed [TRIG_W-1:0] trig_q16(input logic signed [ANGLE_W-1:0] d);
		logic        neg;
		logic [8:0]  a;
		logic [16:0] m;
		neg = d[ANGLE_W-1];
		a = neg ? 9'(-d) : d[8:0];
		if (a >= 9'd360) a = a - 9'd360;
		if (a >= 9'd180) begin
			neg = !neg;
			a = a - 9'd180;
		end
		if (a > 9'd90) a = 9'd180 - a;
		m = sin_mag(a[6:0]);
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage

[sv/tvce_front.sv]
// Front end of the turtle engine: takes commands off the input stream,
// decodes them into queued operations and drops unknown codes.
// Depends on tvce_pkg.
module tvce_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tvce_pkg::S_TDATA_W-1:0]   s_tdata,   // command[2:0], amount[18:3]
	input  logic                             q_full,
	output logic                             push,
	output tvce_pkg::op_t                    push_op
);
	import tvce_pkg::*;

	logic [CMD_W-1:0]        cmd;
	logic signed [AMT_W-1:0] amt;
	logic                    known;

	always_comb begin
		cmd = s_tdata[CMD_W-1:0];
		amt = s_tdata[CMD_W+AMT_W-1:CMD_W];
		known = 1'b1;
		push_op.kind = KIND_MOVE;
		push_op.step = STEP_W'(amt);
		case (cmd)
			CMD_FORWARD: begin
				push_op.kind = KIND_MOVE;
			end
			CMD_BACK: begin
				push_op.kind = KIND_MOVE;
				push_op.step = -STEP_W'(amt);
			end
			CMD_RIGHT: begin
				push_op.kind = KIND_TURN;
			end
			CMD_LEFT: begin
				push_op.kind = KIND_TURN;
				push_op.step = -STEP_W'(amt);
			end
			CMD_PEN_UP: begin
				push_op.kind = KIND_PEN_UP;
			end
			CMD_PEN_DOWN: begin
				push_op.kind = KIND_PEN_DOWN;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full && known;

endmodule

[sv/tvce_queue.sv]
// Short operation queue between front and back end of the turtle engine.
// Depends on tvce_pkg.
module tvce_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tvce_pkg::op_t wr_op,
	output logic          full,
	output logic          valid,
	output tvce_pkg::op_t rd_op,
	input  logic          pop
);
	import tvce_pkg::*;

	op_t            mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign full   = (count_q == (QAW+1)'(QDEPTH));
	assign valid  = (count_q != '0);
	assign rd_op  = mem_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/tvce_back.sv]
// Back end of the turtle engine: heading/pen state, trig lookup, scaled
// step, saturating position update and screen mapping, with output register.
// Depends on tvce_pkg.
module tvce_back #(
	parameter int FRAC_BITS = 16,
	parameter int POS_BITS  = 40
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tvce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tvce_pkg::CENTER_W-1:0]    cfg_data,
	input  logic                             q_valid,
	input  tvce_pkg::op_t                    q_op,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tvce_pkg::M_TDATA_W-1:0]   m_tdata
);
	import tvce_pkg::*;

	localparam int SH_L   = (FRAC_BITS >= TRIG_FRAC) ? FRAC_BITS - TRIG_FRAC : 0;
	localparam int SH_R   = (FRAC_BITS < TRIG_FRAC) ? TRIG_FRAC - FRAC_BITS : 0;
	localparam int BIAS   = (1 << SH_R) - 1;
	localparam int PROD_W = STEP_W + TRIG_W;
	localparam int DW     = PROD_W + SH_L;
	localparam int SW     = ((POS_BITS > DW) ? POS_BITS : DW) + 1;
	localparam int TW     = FRAC_BITS + 19;
	localparam int CW     = ((POS_BITS > TW) ? POS_BITS : TW) + 1;
	localparam int FBIAS  = (1 << FRAC_BITS) - 1;

	localparam logic signed [SW-1:0] SUM_MAX =
		{{(SW-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN =
		{{(SW-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};
	localparam logic signed [CW-1:0] BOUND_HI =
		{{(CW-FRAC_BITS-18){1'b0}}, 1'b1, {(FRAC_BITS+17){1'b0}}};
	localparam logic signed [CW-1:0] BOUND_LO =
		{{(CW-FRAC_BITS-17){1'b1}}, {(FRAC_BITS+17){1'b0}}};
	localparam logic signed [TW-1:0] COORD_MAX = TW'(32767);
	localparam logic signed [TW-1:0] COORD_MIN = TW'(-32768);

	// amount * trig in Q.16, rescaled to FRAC_BITS with truncation toward zero
	function automatic logic signed [DW-1:0] scale(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] b;
		b = p + (p[PROD_W-1] ? PROD_W'(BIAS) : '0);
		return DW'(b >>> SH_R) <<< SH_L;
	endfunction

	function automatic logic signed [POS_BITS-1:0] sat_add(
		input logic signed [POS_BITS-1:0] a,
		input logic signed [DW-1:0]       d
	);
		logic signed [SW-1:0] s;
		s = SW'(a) + SW'(d);
		if (s > SUM_MAX) s = SUM_MAX;
		if (s < SUM_MIN) s = SUM_MIN;
		return s[POS_BITS-1:0];
	endfunction

	// clamp, optional flip, add origin; fraction still attached
	function automatic logic signed [TW-1:0] place(
		input logic signed [POS_BITS-1:0] v,
		input logic                       flip,
		input logic [CENTER_W-1:0]        c
	);
		logic signed [CW-1:0] w;
		w = CW'(v);
		if (w > BOUND_HI) w = BOUND_HI;
		if (w < BOUND_LO) w = BOUND_LO;
		if (flip) w = -w;
		w = w + CW'({c, {FRAC_BITS{1'b0}}});
		return w[TW-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] to_coord(input logic signed [TW-1:0] t);
		logic signed [TW-1:0] b;
		logic signed [TW-1:0] q;
		b = t + (t[TW-1] ? TW'(FBIAS) : '0);
		q = b >>> FRAC_BITS;
		if (q > COORD_MAX) q = COORD_MAX;
		if (q < COORD_MIN) q = COORD_MIN;
		return q[COORD_W-1:0];
	endfunction

	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;

	logic                     adv;
	logic signed [HEAD_W-1:0] heading_q;
	logic                     pen_q;

	logic signed [17:0]       hsum;
	logic [15:0]              hmag;
	logic [31:0]              hprod;
	logic [15:0]              hquo;
	logic [15:0]              hrem_full;
	logic [8:0]               hrem;
	logic signed [HEAD_W-1:0] head_next;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [STEP_W-1:0] amt_s1, amt_s2;
	logic signed [HEAD_W-1:0] heading_s1;
	logic                     pen_s1, pen_s2, pen_s3;
	logic signed [TRIG_W-1:0] sin_s2, cos_s2;
	logic signed [DW-1:0]     dx_s3, dy_s3;

	logic signed [POS_BITS-1:0] pos_x_q, pos_y_q;
	logic signed [POS_BITS-1:0] new_x, new_y;
	logic signed [POS_BITS-1:0] old_x_s4, old_y_s4, new_x_s4, new_y_s4;
	logic signed [TW-1:0]       scol_s5, srow_s5, ecol_s5, erow_s5;

	logic                     m_tvalid_q;
	logic [M_TDATA_W-1:0]     m_tdata_q;

	assign adv = !m_tvalid_q || m_tready;
	assign pop = adv && q_valid;

	// heading remainder by 360, truncated, via reciprocal multiply
	always_comb begin
		hsum      = 18'(heading_q) + 18'(q_op.step);
		hmag      = hsum[17] ? 16'(-hsum) : hsum[15:0];
		hprod     = 32'(hmag) * 32'(RECIP_360);
		hquo      = 16'(hprod >> RECIP_SH);
		hrem_full = hmag - ((hquo << 8) + (hquo << 6) + (hquo << 5) + (hquo << 3));
		hrem      = hrem_full[8:0];
		head_next = hsum[17] ? -$signed({1'b0, hrem}) : $signed({1'b0, hrem});
	end

	assign new_x = sat_add(pos_x_q, dx_s3);
	assign new_y = sat_add(pos_y_q, dy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default:      center_x_q <= center_x_q;
			endcase
		end
	end

	// control state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q  <= '0;
			pen_q      <= 1'b1;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
			valid_s5   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			if (pop) begin
				case (q_op.kind)
					KIND_TURN:     heading_q <= head_next;
					KIND_PEN_UP:   pen_q <= 1'b0;
					KIND_PEN_DOWN: pen_q <= 1'b1;
					default:       heading_q <= heading_q;
				endcase
			end
			if (valid_s3) begin
				pos_x_q <= new_x;
				pos_y_q <= new_y;
			end
			valid_s1   <= pop && (q_op.kind == KIND_MOVE);
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			valid_s4   <= valid_s3 && pen_s3;
			valid_s5   <= valid_s4;
			m_tvalid_q <= valid_s5;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			amt_s1     <= q_op.step;
			heading_s1 <= heading_q;
			pen_s1     <= pen_q;

			amt_s2 <= amt_s1;
			pen_s2 <= pen_s1;
			sin_s2 <= trig_q16(ANGLE_W'(heading_s1));
			cos_s2 <= trig_q16(ANGLE_W'(heading_s1) + 11'sd90);

			pen_s3 <= pen_s2;
			dx_s3  <= scale(PROD_W'(amt_s2) * PROD_W'(sin_s2));
			dy_s3  <= scale(PROD_W'(amt_s2) * PROD_W'(cos_s2));

			old_x_s4 <= pos_x_q;
			old_y_s4 <= pos_y_q;
			new_x_s4 <= new_x;
			new_y_s4 <= new_y;

			scol_s5 <= place(old_x_s4, 1'b0, center_x_q);
			srow_s5 <= place(old_y_s4, 1'b1, center_y_q);
			ecol_s5 <= place(new_x_s4, 1'b0, center_x_q);
			erow_s5 <= place(new_y_s4, 1'b1, center_y_q);

			m_tdata_q <= {to_coord(erow_s5), to_coord(ecol_s5),
				to_coord(srow_s5), to_coord(scol_s5)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		(heading_q <= 10'sd359) && (heading_q >= -10'sd359))
		else $error("heading left -359..359");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (pos_x_q == $past(pos_x_q)) && (pos_y_q == $past(pos_y_q)))
		else $error("position moved during output stall");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(valid_s5))
		else $error("segment appeared without a move in the last stage");

endmodule

[sv/turtle_vector_command_engine_core.sv]
// Turtle vector command engine, top level: turtle-graphics interpreter that
// turns move/turn/pen commands into screen-space line segments.
// Depends on tvce_pkg, tvce_front, tvce_queue and tvce_back.
//
// Takes one command per clock while the queue is not full and returns one
// segment for every forward or back move made with the pen down; turns, pen
// commands and undefined codes give nothing. Position is signed fixed point
// (POS_BITS wide, FRAC_BITS fraction) that saturates; heading is whole degrees
// kept in -359..359 by a truncated remainder. A move adds amount times a Q1.16
// sine/cosine from a 91-entry quarter-wave table. Segments carry screen
// column = x + center_x and row = center_y - y, truncated toward zero and
// clamped to 16 bits. Throughput is one command per cycle while the queue is
// not full; the recurrence that sets it is the heading update (add, reciprocal
// multiply, subtract) which must finish in the cycle a turn leaves the queue.
// A command passes through the queue, the stage registers and the output
// register before its segment appears on m_tdata. A four-entry queue sits
// between the decoder and the execution pipeline, so commands keep being taken
// while a finished segment waits on m_tready. Configuration writes take effect
// at once and should be made only while no command is in flight.
module turtle_vector_command_engine_core #(
	parameter int FRAC_BITS = 16,
	parameter int POS_BITS  = 40
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: index 0 screen_center_x, 1 screen_center_y
	input  logic                             cfg_we,
	input  logic [tvce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tvce_pkg::CENTER_W-1:0]    cfg_data,
	// command stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tvce_pkg::S_TDATA_W-1:0]   s_tdata,   // command[2:0], amount[18:3], zero pad
	// segment stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tvce_pkg::M_TDATA_W-1:0]   m_tdata    // start_col, start_row, end_col, end_row
);
	import tvce_pkg::*;

	logic push;
	op_t  push_op;
	logic q_full;
	logic q_valid;
	op_t  q_op;
	logic pop;

	// decode; unknown command codes are dropped here
	tvce_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	// decouples input acceptance from output stalls
	tvce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (push_op),
		.full   (q_full),
		.valid  (q_valid),
		.rd_op  (q_op),
		.pop    (pop)
	);

	// turtle state and segment pipeline; the whole pipe stalls only
	// when the output register holds an untaken segment
	tvce_back #(
		.FRAC_BITS (FRAC_BITS),
		.POS_BITS  (POS_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

[dv/tb.sv]
// Self-checking bench for turtle_vector_command_engine_core: a scripted opening
// with hand-worked segments, then random command streams under random stalls.
// Depends on tvce_pkg and the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tvce_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int POS_BITS  = 40;

	// codes with no command behind them; the core must drop these
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_col;
		logic signed [COORD_W-1:0] start_row;
		logic signed [COORD_W-1:0] end_col;
		logic signed [COORD_W-1:0] end_row;
	} seg_t;

	localparam seg_t NO_SEG = '0;

	// one scripted command; when fixed is set, seg is the hand-worked segment
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [AMT_W-1:0] amt;
		logic             fixed;
		seg_t             seg;
	} script_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CENTER_W-1:0]    cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;    // command[2:0], amount[18:3], zero pad
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;    // start_col, start_row, end_col, end_row

	turtle_vector_command_engine_core #(
		.FRAC_BITS(FRAC_BITS),
		.POS_BITS (POS_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// turtle state as the bench sees it
	longint              turtle_x;
	longint              turtle_y;
	int                  heading;
	bit                  pen;
	logic [CENTER_W-1:0] origin_x;
	logic [CENTER_W-1:0] origin_y;

	seg_t segs_due[$];
	int   segs_seen;
	int   mismatches;
	int   send_calm;
	int   take_calm;

	// round(65536 * sin(d)) for d = 0..90
	int quarter_sine [0:90] = '{
		0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
		11380, 12505, 13626, 14742, 15854, 16962, 18064, 19161, 20252, 21336,
		22414, 23486, 24550, 25607, 26655, 27696, 28729, 29752, 30767, 31772,
		32768, 33754, 34729, 35693, 36647, 37590, 38521, 39440, 40348, 41243,
		42125, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
		50204, 50931, 51643, 52340, 53020, 53684, 54332, 54963, 55578, 56175,
		56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
		61584, 61966, 62329, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
		64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
		65536
	};

	// Opening script. Hand-worked rows start from reset (origin 512,384):
	// zero-length move, plain moves along y, a move that clips the screen
	// column, and a move from x = -1 after a pen-up move.
	script_row_t opening_script [23] = '{
		'{CMD_FORWARD,  16'd0,       1'b1, '{16'sd512, 16'sd384, 16'sd512, 16'sd384}},
		'{CMD_FORWARD,  16'd100,     1'b1, '{16'sd512, 16'sd384, 16'sd512, 16'sd284}},
		'{CMD_BACK,     16'd100,     1'b1, '{16'sd512, 16'sd284, 16'sd512, 16'sd384}},
		'{CMD_RIGHT,    16'd90,      1'b0, NO_SEG},
		'{CMD_FORWARD,  16'sh7FFF,   1'b1, '{16'sd512, 16'sd384, 16'sd32767, 16'sd384}},
		'{CMD_RSVD6,    16'sh8000,   1'b0, NO_SEG},
		'{CMD_RSVD7,    16'sh7FFF,   1'b0, NO_SEG},
		'{CMD_PEN_UP,   16'shFFFF,   1'b0, NO_SEG},
		'{CMD_FORWARD,  16'sh8000,   1'b0, NO_SEG},
		'{CMD_PEN_DOWN, 16'sh5A5A,   1'b0, NO_SEG},
		'{CMD_FORWARD,  16'd1,       1'b1, '{16'sd511, 16'sd384, 16'sd512, 16'sd384}},
		'{CMD_LEFT,     16'sh8000,   1'b0, NO_SEG},
		'{CMD_FORWARD,  16'sh8000,   1'b0, NO_SEG},
		'{CMD_RIGHT,    16'sh7FFF,   1'b0, NO_SEG},
		'{CMD_BACK,     16'sh8000,   1'b0, NO_SEG},
		'{CMD_RIGHT,    -16'sd45,    1'b0, NO_SEG},
		'{CMD_FORWARD,  16'd1234,    1'b0, NO_SEG},
		'{CMD_LEFT,     16'd359,     1'b0, NO_SEG},
		'{CMD_BACK,     16'd0,       1'b0, NO_SEG},
		'{CMD_RIGHT,    16'h0B3F,    1'b0, NO_SEG},
		'{CMD_FORWARD,  16'd7,       1'b0, NO_SEG},
		'{CMD_PEN_UP,   16'd0,       1'b0, NO_SEG},
		'{CMD_PEN_DOWN, 16'd0,       1'b0, NO_SEG}
	};

	// ---------------------------------------------------------------
	// Turtle predictor
	// ---------------------------------------------------------------

	// Q1.16 sine of a whole-degree angle, quadrant folded
	function automatic int sine_deg(input int d);
		bit neg;
		neg = (d < 0);
		if (neg) d = -d;
		d = d % 360;
		if (d >= 180) begin
			neg = !neg;
			d = d - 180;
		end
		if (d > 90) d = 180 - d;
		return neg ? -quarter_sine[d] : quarter_sine[d];
	endfunction

	// amount * Q1.16 trig, brought to FRAC_BITS (truncating when narrower)
	function automatic longint scale_step(input int amt, input int trig);
		longint p;
		p = longint'(amt) * longint'(trig);
		if (FRAC_BITS >= TRIG_FRAC) return p * (longint'(1) << (FRAC_BITS - TRIG_FRAC));
		return p / (longint'(1) << (TRIG_FRAC - FRAC_BITS));
	endfunction

	function automatic longint clamp_pos(input longint a, input longint d);
		longint hi;
		longint lo;
		hi = (longint'(1) << (POS_BITS - 1)) - 1;
		lo = -hi - 1;
		if (d > 0 && a > hi - d) return hi;
		if (d < 0 && a < lo - d) return lo;
		return a + d;
	endfunction

	// fixed-point coordinate to screen: optional y flip, add origin,
	// truncate toward zero, clamp to 16 bits
	function automatic logic signed [COORD_W-1:0] screen_coord(input longint v,
			input bit flip, input logic [CENTER_W-1:0] c);
		longint lim;
		longint t;
		lim = longint'(1) << (FRAC_BITS + 17);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		if (flip) v = -v;
		t = v + (longint'(c) << FRAC_BITS);
		t = t / (longint'(1) << FRAC_BITS);
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[COORD_W-1:0];
	endfunction

	// advance the turtle by one command; returns 1 when a segment is drawn
	function automatic bit turtle_step(input logic [CMD_W-1:0] cmd,
			input logic signed [AMT_W-1:0] amt_in, output seg_t seg);
		int     amt;
		longint nx;
		longint ny;
		bit     drawn;
		amt = amt_in;
		seg = NO_SEG;
		drawn = 1'b0;
		case (cmd)
			CMD_FORWARD, CMD_BACK: begin
				if (cmd == CMD_BACK) amt = -amt;
				nx = clamp_pos(turtle_x, scale_step(amt, sine_deg(heading)));
				ny = clamp_pos(turtle_y, scale_step(amt, sine_deg(heading + 90)));
				seg.start_col = screen_coord(turtle_x, 1'b0, origin_x);
				seg.start_row = screen_coord(turtle_y, 1'b1, origin_y);
				seg.end_col   = screen_coord(nx, 1'b0, origin_x);
				seg.end_row   = screen_coord(ny, 1'b1, origin_y);
				turtle_x = nx;
				turtle_y = ny;
				drawn = pen;
			end
			CMD_RIGHT, CMD_LEFT: begin
				if (cmd == CMD_LEFT) amt = -amt;
				heading = (heading + amt) % 360;   // truncated remainder, like C
			end
			CMD_PEN_UP: begin
				pen = 1'b0;
			end
			CMD_PEN_DOWN: begin
				pen = 1'b1;
			end
			default: begin
			end
		endcase
		return drawn;
	endfunction

	// ---------------------------------------------------------------
	// Stall pattern: mostly a random idle gap before each item, with runs of
	// back-to-back items now and then
	// ---------------------------------------------------------------
	function automatic int next_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	task automatic log_error(input string msg);
		mismatches++;
		$display("%t  %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic signed [COORD_W-1:0] got,
			input logic signed [COORD_W-1:0] want);
		if (got !== want)
			log_error($sformatf("segment %0d %s: got %0d, expected %0d",
				segs_seen, name, got, want));
	endtask

	// ---------------------------------------------------------------
	// Command side
	// ---------------------------------------------------------------

	// offer one item, wait for it to be taken, then predict it
	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [AMT_W-1:0] amt,
			input bit fixed, input seg_t fixed_seg);
		int   gap;
		seg_t seg;
		gap = next_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, amt, cmd};
		do @(posedge clk); while (!s_tready);
		if (turtle_step(cmd, amt, seg)) segs_due.push_back(fixed ? fixed_seg : seg);
	endtask

	// moves dominate; turns lean to multiples of 45 and small angles so the
	// table ends and quadrant folds get hit often
	task automatic issue_random();
		int               r;
		logic [CMD_W-1:0] cmd;
		logic [AMT_W-1:0] amt;
		r = $urandom_range(0, 99);
		amt = 16'($urandom_range(0, 65535));
		if (r < 50) begin
			cmd = $urandom_range(0, 1) ? CMD_BACK : CMD_FORWARD;
			if ($urandom_range(0, 1)) amt = 16'($urandom_range(0, 600)) - 16'd300;
		end else if (r < 75) begin
			cmd = $urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT;
			case ($urandom_range(0, 2))
				0: amt = 16'(45 * $urandom_range(0, 16)) - 16'd360;
				1: amt = 16'($urandom_range(0, 800)) - 16'd400;
				default: begin
				end
			endcase
		end else if (r < 83) begin
			cmd = CMD_PEN_UP;
		end else if (r < 93) begin
			cmd = CMD_PEN_DOWN;
		end else begin
			cmd = $urandom_range(0, 1) ? CMD_RSVD7 : CMD_RSVD6;
		end
		issue(cmd, amt, 1'b0, NO_SEG);
	endtask

	// square up to an axis and drive near-full-length moves one way until
	// that coordinate pins at the edge of its range
	task automatic issue_straight_run();
		int aim;
		int mag;
		aim = 90 * $urandom_range(0, 3);
		issue(CMD_PEN_DOWN, 16'd0, 1'b0, NO_SEG);
		issue(CMD_RIGHT, 16'(aim - heading), 1'b0, NO_SEG);
		for (int i = 0; i < 265; i++) begin
			mag = $urandom_range(32000, 32767);
			if ($urandom_range(0, 1)) issue(CMD_FORWARD, 16'(mag), 1'b0, NO_SEG);
			else issue(CMD_BACK, 16'(-mag), 1'b0, NO_SEG);
		end
	endtask

	// new origin, only once the pipe has drained; turns and pen commands
	// leave nothing to wait on, so give the pipeline time to empty too
	task automatic set_origin(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy);
		s_tvalid <= 1'b0;
		while (segs_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_data  <= cx;
		@(posedge clk);
		cfg_index <= REG_CENTER_Y;
		cfg_data  <= cy;
		@(posedge clk);
		cfg_we    <= 1'b0;
		origin_x = cx;
		origin_y = cy;
	endtask

	// ---------------------------------------------------------------
	// Clock, reset, stimulus
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		turtle_x  = 0;
		turtle_y  = 0;
		heading   = 0;
		pen       = 1'b1;
		origin_x  = CENTER_X_RST;
		origin_y  = CENTER_Y_RST;
		send_calm = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_script[i])
			issue(opening_script[i].cmd, opening_script[i].amt,
				opening_script[i].fixed, opening_script[i].seg);

		// origin at both corners and in between; position carries over
		set_origin(12'd0, 12'd0);
		repeat (45) issue_random();
		set_origin(12'd4095, 12'd4095);
		issue_straight_run();
		repeat (45) issue_random();
		set_origin(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		repeat (45) issue_random();
		set_origin(12'd4095, 12'd0);
		repeat (45) issue_random();
		set_origin(12'd0, 12'd4095);
		repeat (45) issue_random();

		s_tvalid <= 1'b0;
		while (segs_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[turtle_vector_command_engine_core] OK");
		end else begin
			$display("[turtle_vector_command_engine_core] ERROR");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// Segment side: random back-pressure, plus one long hold-off early on
	// so the queue and the pipe fill up and s_tready has to drop
	// ---------------------------------------------------------------
	initial begin
		int gap;
		bit held;
		m_tready <= 1'b0;
		take_calm = 0;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && segs_seen >= 30) begin
				held = 1'b1;
				gap = 200;
			end else begin
				gap = next_gap(take_calm);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// scoreboard: every segment taken is matched against the oldest prediction
	always @(posedge clk) begin
		seg_t got;
		seg_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.start_col = m_tdata[15:0];
			got.start_row = m_tdata[31:16];
			got.end_col   = m_tdata[47:32];
			got.end_row   = m_tdata[63:48];
			segs_seen++;
			if (segs_due.size() == 0) begin
				log_error($sformatf("segment %0d arrived with none pending", segs_seen));
			end else begin
				want = segs_due.pop_front();
				check_field("start_col", got.start_col, want.start_col);
				check_field("start_row", got.start_row, want.start_row);
				check_field("end_col", got.end_col, want.end_col);
				check_field("end_row", got.end_row, want.end_row);
			end
		end
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("[turtle_vector_command_engine_core] ERROR");
		$finish;
	end

endmodule
